[sv/bis_pkg.sv]
`timescale 1ns / 1ps

package bis_pkg;

   // default sizes of the image store and the number formats
   localparam int MAX_COLS_DEF    = 256;
   localparam int MAX_ROWS_DEF    = 256;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 8;

   // fixed widths of the port fields
   localparam int POS_W      = 16;
   localparam int CHAN_W     = 2;
   localparam int DATA_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // integer coordinates with room for the ceil neighbor
   localparam int COORD_W = POS_W + 1;

   localparam int PLANES      = 3;
   localparam int CORNERS     = 4;
   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] IMAGE_COLS_RST = 9'd256;
   localparam logic [CSR_DATA_W-1:0] IMAGE_ROWS_RST = 9'd256;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_COLS = 2'd0,
      CSR_IMAGE_ROWS = 2'd1
   } csr_index_type;

   // request action codes
   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   // what the back end does with one queued command
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ZERO  = 2'd1,
      CMD_BLEND = 2'd2
   } cmd_kind_type;

   // width of one queued command: kind, outside, plane, four corners, sample
   function automatic int cmd_bits(int row_w, int col_w, int wgt_w, int sample_w);
      return $bits(cmd_kind_type) + 1 + CHAN_W + CORNERS * (row_w + col_w + wgt_w)
             + sample_w;
   endfunction

endpackage

[sv/bis_ram.sv]
`timescale 1ns / 1ps

module bis_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/bis_queue.sv]
`timescale 1ns / 1ps

module bis_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bis_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full)
      else $error("queue pushed while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      full |=> (count_ff == CNT_W'(DEPTH)) || ($past(pop) && !$past(push)))
      else $error("queue fill count left full without a pop");

endmodule

[sv/bis_front.sv]
`timescale 1ns / 1ps

module bis_front #(
   parameter int MAX_COLS    = bis_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = bis_pkg::MAX_ROWS_DEF,
   parameter int SAMPLE_BITS = bis_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = bis_pkg::FRAC_BITS_DEF,
   parameter int CMD_W       = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bis_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [bis_pkg::POS_W-1:0]       req_pos_x,
   input  logic [bis_pkg::POS_W-1:0]       req_pos_y,
   input  logic [bis_pkg::CHAN_W-1:0]      req_channel,
   input  logic [bis_pkg::DATA_W-1:0]      req_sample_in,
   output logic                            q_push,
   output logic [CMD_W-1:0]                q_data,
   input  logic                            q_full
);

   localparam int COORD_W    = bis_pkg::COORD_W;
   localparam int POS_W      = bis_pkg::POS_W;
   localparam int CHAN_W     = bis_pkg::CHAN_W;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int WGT_W      = 2 * FRAC_BITS + 1;
   localparam int GW         = FRAC_BITS + 1;
   localparam int DIRECT_MAX = ((1 << FRAC_BITS) - 1) / 100;

   typedef struct packed {
      bis_pkg::cmd_kind_type                   kind;
      logic                                    outside;
      logic [CHAN_W-1:0]                       plane;
      logic [bis_pkg::CORNERS-1:0][ROW_W-1:0]  row;
      logic [bis_pkg::CORNERS-1:0][COL_W-1:0]  col;
      logic [bis_pkg::CORNERS-1:0][WGT_W-1:0]  wgt;
      logic [SAMPLE_BITS-1:0]                  data;
   } cmd_type;

   logic [bis_pkg::CSR_DATA_W-1:0] image_cols_ff, image_cols_in;
   logic [bis_pkg::CSR_DATA_W-1:0] image_rows_ff, image_rows_in;

   logic [COORD_W-1:0]   cols, rows;
   logic [COORD_W-1:0]   ix, iy, cx, cy;
   logic [FRAC_BITS-1:0] fx, fy;
   logic [GW-1:0]        gx, gy;
   logic [2*GW-1:0]      w_ff_full, w_cf_full, w_fc_full, w_cc_full;
   logic                 in_image, plane_ok, direct, keep;
   logic                 bd_c2, bd_c3, bd_c4;
   cmd_type              cmd;

   function automatic logic at_border(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                                      logic [COORD_W-1:0] nc, logic [COORD_W-1:0] nr);
      logic res;
      res = (c == '0) || (c >= nc - COORD_W'(1)) || (r == '0) || (r >= nr - COORD_W'(1));
      return res;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_size(logic [bis_pkg::CSR_DATA_W-1:0] v,
                                                     int hi);
      logic [COORD_W-1:0] res;
      res = COORD_W'(v);
      if (res < COORD_W'(2)) begin
         res = COORD_W'(2);
      end else if (res > COORD_W'(hi)) begin
         res = COORD_W'(hi);
      end
      return res;
   endfunction

   // configuration registers, always ready
   always_comb begin
      image_cols_in = image_cols_ff;
      image_rows_in = image_rows_ff;
      if (csr_valid) begin
         case (csr_index)
            bis_pkg::CSR_IMAGE_COLS: image_cols_in = csr_data;
            bis_pkg::CSR_IMAGE_ROWS: image_rows_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_cols_ff <= bis_pkg::IMAGE_COLS_RST;
         image_rows_ff <= bis_pkg::IMAGE_ROWS_RST;
      end else begin
         image_cols_ff <= image_cols_in;
         image_rows_ff <= image_rows_in;
      end
   end

   assign csr_ready = 1'b1;

   // position split and bounds
   assign cols = clamp_size(image_cols_ff, MAX_COLS);
   assign rows = clamp_size(image_rows_ff, MAX_ROWS);
   assign ix   = COORD_W'(req_pos_x[POS_W-1:FRAC_BITS]);
   assign iy   = COORD_W'(req_pos_y[POS_W-1:FRAC_BITS]);
   assign fx   = req_pos_x[FRAC_BITS-1:0];
   assign fy   = req_pos_y[FRAC_BITS-1:0];
   assign cx   = ix + COORD_W'(fx != '0);
   assign cy   = iy + COORD_W'(fy != '0);

   assign in_image = (ix < cols) && (iy < rows);
   assign plane_ok = (req_channel < CHAN_W'(bis_pkg::PLANES));
   assign direct   = (fx <= FRAC_BITS'(DIRECT_MAX)) && (fy <= FRAC_BITS'(DIRECT_MAX));

   // border neighbors, and every neighbor of a direct return, fall back to the floor corner
   assign bd_c2 = direct || at_border(cx, iy, cols, rows);
   assign bd_c3 = direct || at_border(ix, cy, cols, rows);
   assign bd_c4 = direct || at_border(cx, cy, cols, rows);

   // bilinear weights
   assign gx        = GW'(1 << FRAC_BITS) - GW'(fx);
   assign gy        = GW'(1 << FRAC_BITS) - GW'(fy);
   assign w_ff_full = gx * gy;
   assign w_cf_full = GW'(fx) * gy;
   assign w_fc_full = gx * GW'(fy);
   assign w_cc_full = GW'(fx) * GW'(fy);

   // classify and build the command
   always_comb begin
      cmd.outside = !in_image;
      cmd.plane   = req_channel;
      cmd.data    = SAMPLE_BITS'(req_sample_in);
      cmd.row[0]  = ROW_W'(iy);
      cmd.col[0]  = COL_W'(ix);
      cmd.row[1]  = ROW_W'(iy);
      cmd.col[1]  = bd_c2 ? COL_W'(ix) : COL_W'(cx);
      cmd.row[2]  = bd_c3 ? ROW_W'(iy) : ROW_W'(cy);
      cmd.col[2]  = COL_W'(ix);
      cmd.row[3]  = bd_c4 ? ROW_W'(iy) : ROW_W'(cy);
      cmd.col[3]  = bd_c4 ? COL_W'(ix) : COL_W'(cx);
      if (direct) begin
         cmd.wgt[0] = WGT_W'(1) << (2 * FRAC_BITS);
         cmd.wgt[1] = '0;
         cmd.wgt[2] = '0;
         cmd.wgt[3] = '0;
      end else begin
         cmd.wgt[0] = w_ff_full[WGT_W-1:0];
         cmd.wgt[1] = w_cf_full[WGT_W-1:0];
         cmd.wgt[2] = w_fc_full[WGT_W-1:0];
         cmd.wgt[3] = w_cc_full[WGT_W-1:0];
      end
      if (req_action == bis_pkg::ACT_LOAD) begin
         cmd.kind = bis_pkg::CMD_LOAD;
         keep     = in_image && plane_ok;
      end else if (!in_image || !plane_ok) begin
         cmd.kind = bis_pkg::CMD_ZERO;
         keep     = 1'b1;
      end else begin
         cmd.kind = bis_pkg::CMD_BLEND;
         keep     = 1'b1;
      end
   end

   assign busy   = q_full;
   assign q_push = start && !q_full && keep;
   assign q_data = cmd;

endmodule

[sv/bis_back.sv]
`timescale 1ns / 1ps

module bis_back #(
   parameter int MAX_COLS    = bis_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = bis_pkg::MAX_ROWS_DEF,
   parameter int SAMPLE_BITS = bis_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = bis_pkg::FRAC_BITS_DEF,
   parameter int CMD_W       = 64,
   parameter int ADDR_W      = 18
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CMD_W-1:0]            q_head,
   input  logic                        q_empty,
   output logic                        q_pop,
   output logic                        ram_en,
   output logic                        ram_we,
   output logic [ADDR_W-1:0]           ram_addr,
   output logic [SAMPLE_BITS-1:0]      ram_wdata,
   input  logic [SAMPLE_BITS-1:0]      ram_rdata,
   output logic                        rsp_valid,
   output logic [bis_pkg::DATA_W-1:0]  rsp_sample_out,
   output logic                        rsp_outside
);

   localparam int CHAN_W     = bis_pkg::CHAN_W;
   localparam int DATA_W     = bis_pkg::DATA_W;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int WGT_W      = 2 * FRAC_BITS + 1;
   localparam int ACC_W      = SAMPLE_BITS + 2 * FRAC_BITS;
   localparam int PROD_W     = SAMPLE_BITS + WGT_W;
   localparam int K_W        = $clog2(bis_pkg::CORNERS);
   localparam int PLANE_SIZE = MAX_ROWS * MAX_COLS;

   typedef struct packed {
      bis_pkg::cmd_kind_type                   kind;
      logic                                    outside;
      logic [CHAN_W-1:0]                       plane;
      logic [bis_pkg::CORNERS-1:0][ROW_W-1:0]  row;
      logic [bis_pkg::CORNERS-1:0][COL_W-1:0]  col;
      logic [bis_pkg::CORNERS-1:0][WGT_W-1:0]  wgt;
      logic [SAMPLE_BITS-1:0]                  data;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   localparam logic [K_W-1:0] K_LAST = K_W'(bis_pkg::CORNERS - 1);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   cmd_type              head, sel;
   logic [K_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [K_W-1:0]       sel_k;
   logic                 rd_v_ff, rd_v_in;
   logic [K_W-1:0]       rd_k_ff;
   logic                 prod_v_ff, prod_last_ff;
   logic [ACC_W-1:0]     prod_ff;
   logic [PROD_W-1:0]    prod_full;
   logic [ACC_W-1:0]     acc_ff, acc_in, acc_sum;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                 rsp_outside_ff, rsp_outside_in;

   assign head  = q_head;
   assign sel   = (state_ff == ST_IDLE) ? head : cmd_ff;
   assign sel_k = (state_ff == ST_IDLE) ? '0 : rd_idx_ff;

   // store address of the selected corner
   assign ram_addr = ADDR_W'(sel.plane) * ADDR_W'(PLANE_SIZE)
                   + ADDR_W'(sel.row[sel_k]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(sel.col[sel_k]);
   assign ram_wdata = sel.data;

   // weighted pixel, one corner a cycle
   assign prod_full = ram_rdata * cmd_ff.wgt[rd_k_ff];
   assign acc_sum   = acc_ff + prod_ff;

   // sequencer: loads and zero results complete in the idle state, blends over four reads
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      rd_idx_in      = rd_idx_ff;
      q_pop          = 1'b0;
      ram_en         = 1'b0;
      ram_we         = 1'b0;
      acc_in         = acc_ff;
      rsp_valid_in   = 1'b0;
      rsp_sample_in  = rsp_sample_ff;
      rsp_outside_in = rsp_outside_ff;

      // accumulate and finish
      if (prod_v_ff) begin
         acc_in = acc_sum;
      end
      if (prod_last_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_sample_in  = DATA_W'(acc_sum >> (2 * FRAC_BITS));
         rsp_outside_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = head;
               case (head.kind)
                  bis_pkg::CMD_LOAD: begin
                     ram_en = 1'b1;
                     ram_we = 1'b1;
                  end
                  bis_pkg::CMD_ZERO: begin
                     rsp_valid_in   = 1'b1;
                     rsp_sample_in  = '0;
                     rsp_outside_in = head.outside;
                  end
                  bis_pkg::CMD_BLEND: begin
                     ram_en    = 1'b1;
                     acc_in    = ACC_W'(1) << (2 * FRAC_BITS - 1);
                     rd_idx_in = K_W'(1);
                     state_in  = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            ram_en    = 1'b1;
            rd_idx_in = rd_idx_ff + K_W'(1);
            if (rd_idx_ff == K_LAST) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (prod_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rd_v_in = ram_en && !ram_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         prod_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= rd_v_ff;
         prod_last_ff <= rd_v_ff && (rd_k_ff == K_LAST);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      rd_idx_ff      <= rd_idx_in;
      rd_k_ff        <= sel_k;
      prod_ff        <= prod_full[ACC_W-1:0];
      acc_ff         <= acc_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_outside    = rsp_outside_ff;

   a_last_in_wait: assert property (@(posedge clock) disable iff (reset)
      prod_last_ff |-> state_ff == ST_WAIT)
      else $error("final product arrived outside the wait state");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE && q_pop)
      else $error("store write during a blend");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_outside_ff |-> rsp_sample_ff == '0)
      else $error("outside result carries a nonzero sample");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE && !prod_v_ff)
      else $error("command taken while a blend is in flight");

endmodule

[sv/bilinear_image_sampler.sv]
`timescale 1ns / 1ps

// channel     direction  handshake                     payload
// request     in         start && !busy                req_action, req_pos_x, req_pos_y,
//                                                      req_channel, req_sample_in
// response    out        rsp_valid, one-cycle strobe   rsp_sample_out, rsp_outside
// csr write   in         csr_valid && csr_ready        csr_index, csr_data
//
// a load in the image is one store write; an outside or plane-three sample needs no store read
// an interpolated sample makes four corner reads through the single store port, then
// drains through the registered multiply and accumulate
// accepted samples pass through the command queue and leave from the response registers
// reset is synchronous; the image store has no reset and no clearing pass
// busy rises only while the two-entry command queue is full; responses cannot stall

module bilinear_image_sampler #(
   parameter int MAX_COLS    = bis_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = bis_pkg::MAX_ROWS_DEF,
   parameter int SAMPLE_BITS = bis_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = bis_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bis_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [bis_pkg::POS_W-1:0]       req_pos_x,
   input  logic [bis_pkg::POS_W-1:0]       req_pos_y,
   input  logic [bis_pkg::CHAN_W-1:0]      req_channel,
   input  logic [bis_pkg::DATA_W-1:0]      req_sample_in,
   output logic                            rsp_valid,
   output logic [bis_pkg::DATA_W-1:0]      rsp_sample_out,
   output logic                            rsp_outside
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int WGT_W  = 2 * FRAC_BITS + 1;
   localparam int CMD_W  = bis_pkg::cmd_bits(ROW_W, COL_W, WGT_W, SAMPLE_BITS);
   localparam int DEPTH  = bis_pkg::PLANES * MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                   q_push, q_pop, q_empty, q_full;
   logic [CMD_W-1:0]       q_data, q_head;
   logic                   ram_en, ram_we;
   logic [ADDR_W-1:0]      ram_addr;
   logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

   // accept, classify, hold configuration
   bis_front #(
      .MAX_COLS    (MAX_COLS),
      .MAX_ROWS    (MAX_ROWS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .CMD_W       (CMD_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_channel   (req_channel),
      .req_sample_in (req_sample_in),
      .q_push        (q_push),
      .q_data        (q_data),
      .q_full        (q_full)
   );

   // command queue between front and back
   bis_queue #(
      .WIDTH (CMD_W),
      .DEPTH (bis_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // store access and blend
   bis_back #(
      .MAX_COLS    (MAX_COLS),
      .MAX_ROWS    (MAX_ROWS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .CMD_W       (CMD_W),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .ram_en         (ram_en),
      .ram_we         (ram_we),
      .ram_addr       (ram_addr),
      .ram_wdata      (ram_wdata),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_outside    (rsp_outside)
   );

   // three-plane image store
   bis_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

[tb/sampler_checker.sv]
`timescale 1ns / 1ps

module sampler_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_action,
   input  logic [bis_pkg::POS_W-1:0]      req_pos_x,
   input  logic [bis_pkg::POS_W-1:0]      req_pos_y,
   input  logic [bis_pkg::CHAN_W-1:0]     req_channel,
   input  logic [bis_pkg::DATA_W-1:0]     req_sample_in,
   input  logic                           rsp_valid,
   input  logic [bis_pkg::DATA_W-1:0]     rsp_sample_out,
   input  logic                           rsp_outside,
   output int                             mismatch_count,
   output int                             outstanding
);

   import bis_pkg::*;

   localparam int          PLANE_WORDS = MAX_ROWS_DEF * MAX_COLS_DEF;
   localparam int          STORE_WORDS = PLANES * PLANE_WORDS;
   localparam int unsigned ONE         = 1 << FRAC_BITS_DEF;
   localparam int unsigned FRAC_MASK   = ONE - 1;

   typedef struct packed {
      logic [DATA_W-1:0] pixel;
      logic              outside;
   } sample_result_t;

   // shadow image and size registers
   logic [DATA_W-1:0]     pix_mem [0:STORE_WORDS-1];
   logic [CSR_DATA_W-1:0] cols_reg;
   logic [CSR_DATA_W-1:0] rows_reg;
   sample_result_t        expected_pixels[$];
   int                    errors = 0;

   // register value as the block uses it
   function automatic int unsigned size_in_use(logic [CSR_DATA_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [63:0] read_pixel(int unsigned plane, int unsigned row,
                                              int unsigned col);
      int unsigned a;
      a = (plane * MAX_ROWS_DEF + row) * MAX_COLS_DEF + col;
      if (a >= STORE_WORDS) return 64'd0;
      return 64'(pix_mem[a]);
   endfunction

   function automatic bit on_border(int unsigned col, int unsigned row,
                                    int unsigned cols, int unsigned rows);
      return col == 0 || col >= cols - 1 || row == 0 || row >= rows - 1;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // loads update the shadow image, samples queue their expected pixel
   task automatic blend_or_store();
      int unsigned    cols, rows, ix, iy, fx, fy, cx, cy, plane;
      logic [63:0]    c1, c2, c3, c4, gx, gy, acc;
      sample_result_t res;
      cols  = size_in_use(cols_reg, MAX_COLS_DEF);
      rows  = size_in_use(rows_reg, MAX_ROWS_DEF);
      ix    = req_pos_x >> FRAC_BITS_DEF;
      iy    = req_pos_y >> FRAC_BITS_DEF;
      fx    = req_pos_x & FRAC_MASK;
      fy    = req_pos_y & FRAC_MASK;
      plane = req_channel;
      if (req_action == ACT_LOAD) begin
         if (plane < PLANES && ix < cols && iy < rows)
            pix_mem[(plane * MAX_ROWS_DEF + iy) * MAX_COLS_DEF + ix] = req_sample_in;
         return;
      end
      res.pixel   = '0;
      res.outside = (ix >= cols || iy >= rows);
      if (!res.outside && plane < PLANES) begin
         if (fx * 100 < ONE && fy * 100 < ONE) begin
            // fractions too small to matter: stored pixel as is
            res.pixel = DATA_W'(read_pixel(plane, iy, ix));
         end else begin
            // four corners, border ones fall back to the floor corner
            cx  = ix + ((fx != 0) ? 1 : 0);
            cy  = iy + ((fy != 0) ? 1 : 0);
            c1  = read_pixel(plane, iy, ix);
            c2  = on_border(cx, iy, cols, rows) ? c1 : read_pixel(plane, iy, cx);
            c3  = on_border(ix, cy, cols, rows) ? c1 : read_pixel(plane, cy, ix);
            c4  = on_border(cx, cy, cols, rows) ? c1 : read_pixel(plane, cy, cx);
            gx  = 64'(ONE - fx);
            gy  = 64'(ONE - fy);
            acc = c1 * (gx * gy) + c2 * (64'(fx) * gy) + c3 * (gx * 64'(fy))
                  + c4 * (64'(fx) * 64'(fy));
            acc = acc + (64'd1 << (2 * FRAC_BITS_DEF - 1));
            res.pixel = DATA_W'(acc >> (2 * FRAC_BITS_DEF));
         end
      end
      expected_pixels.push_back(res);
   endtask

   task automatic check_result();
      sample_result_t want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected result sample_out %h outside %b",
                                   rsp_sample_out, rsp_outside));
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_sample_out !== want.pixel)
         report_mismatch($sformatf("sample_out %h, expected %h", rsp_sample_out, want.pixel));
      if (rsp_outside !== want.outside)
         report_mismatch($sformatf("outside %b, expected %b", rsp_outside, want.outside));
   endtask

   // observe every transaction on the three channels
   always @(posedge clock) begin
      if (reset) begin
         cols_reg = IMAGE_COLS_RST;
         rows_reg = IMAGE_ROWS_RST;
         expected_pixels.delete();
      end else begin
         if (rsp_valid) check_result();
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_COLS) cols_reg = csr_data;
            else if (csr_index == CSR_IMAGE_ROWS) rows_reg = csr_data;
         end
         if (start && !busy) blend_or_store();
      end
      mismatch_count <= errors;
      outstanding    <= expected_pixels.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   import bis_pkg::*;

   localparam int          STALL_LIMIT   = 2000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int unsigned ONE           = 1 << FRAC_BITS_DEF;

   typedef struct {
      int unsigned x0;
      int unsigned y0;
      int unsigned w;
      int unsigned h;
   } patch_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_IMAGE_COLS;
   logic [CSR_DATA_W-1:0] csr_data    = '0;
   logic                  start       = 1'b0;
   logic                  busy;
   logic                  req_action  = ACT_LOAD;
   logic [POS_W-1:0]      req_pos_x   = '0;
   logic [POS_W-1:0]      req_pos_y   = '0;
   logic [CHAN_W-1:0]     req_channel = '0;
   logic [DATA_W-1:0]     req_sample_in = '0;
   logic                  rsp_valid;
   logic [DATA_W-1:0]     rsp_sample_out;
   logic                  rsp_outside;
   int                    fail_count;
   int                    outstanding;

   // which store entries hold a written value, and the image size in use
   bit          img_written [0:PLANES*MAX_ROWS_DEF*MAX_COLS_DEF-1];
   int unsigned cols_eff = MAX_COLS_DEF;
   int unsigned rows_eff = MAX_ROWS_DEF;
   bit          burst    = 1'b0;
   int          n_loads  = 0;
   int          n_samples = 0;
   int          n_sizes  = 1;

   bilinear_image_sampler u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_channel    (req_channel),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_outside    (rsp_outside)
   );

   sampler_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_channel    (req_channel),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_outside    (rsp_outside),
      .mismatch_count (fail_count),
      .outstanding    (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: any accepted transaction restarts the count
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("stalled for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int unsigned effective_size(logic [CSR_DATA_W-1:0] v, int unsigned hi);
      return (v < 2) ? 2 : ((v > hi) ? hi : v);
   endfunction

   function automatic bit on_border(int unsigned col, int unsigned row);
      return col == 0 || col >= cols_eff - 1 || row == 0 || row >= rows_eff - 1;
   endfunction

   function automatic bit is_written(int unsigned plane, int unsigned row, int unsigned col);
      return img_written[(plane * MAX_ROWS_DEF + row) * MAX_COLS_DEF + col];
   endfunction

   // true when every pixel the sample would read has been loaded
   function automatic bit reads_written(int unsigned plane, logic [POS_W-1:0] px,
                                        logic [POS_W-1:0] py);
      int unsigned ix, iy, fx, fy, cx, cy;
      ix = px >> FRAC_BITS_DEF;
      iy = py >> FRAC_BITS_DEF;
      fx = px & (ONE - 1);
      fy = py & (ONE - 1);
      if (ix >= cols_eff || iy >= rows_eff || plane >= PLANES) return 1'b1;
      if (!is_written(plane, iy, ix)) return 1'b0;
      if (fx * 100 < ONE && fy * 100 < ONE) return 1'b1;
      cx = ix + ((fx != 0) ? 1 : 0);
      cy = iy + ((fy != 0) ? 1 : 0);
      if (!on_border(cx, iy) && !is_written(plane, iy, cx)) return 1'b0;
      if (!on_border(ix, cy) && !is_written(plane, cy, ix)) return 1'b0;
      if (!on_border(cx, cy) && !is_written(plane, cy, cx)) return 1'b0;
      return 1'b1;
   endfunction

   // fraction biased toward zero and the direct-return threshold
   function automatic int unsigned frac_draw();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return $urandom_range(0, 3);
         default: return $urandom_range(0, ONE - 1);
      endcase
   endfunction

   // one request transaction, with a random gap before it outside burst mode
   task automatic send_item(input action_type act, input logic [POS_W-1:0] px,
                            input logic [POS_W-1:0] py, input logic [CHAN_W-1:0] ch,
                            input logic [DATA_W-1:0] val);
      int unsigned gap, ix, iy;
      gap = burst ? 0 : $urandom_range(0, 4);
      ix  = px >> FRAC_BITS_DEF;
      iy  = py >> FRAC_BITS_DEF;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_pos_x     <= px;
      req_pos_y     <= py;
      req_channel   <= ch;
      req_sample_in <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (act == ACT_LOAD) begin
         n_loads++;
         if (ch < PLANES && ix < cols_eff && iy < rows_eff)
            img_written[(ch * MAX_ROWS_DEF + iy) * MAX_COLS_DEF + ix] = 1'b1;
      end else begin
         n_samples++;
      end
   endtask

   // stop sending and let every result and queued load drain
   task automatic settle_block();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_DATA_W-1:0] c_raw,
                             input logic [CSR_DATA_W-1:0] r_raw);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_COLS;
      csr_data  <= c_raw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_IMAGE_ROWS;
      csr_data  <= r_raw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      cols_eff = effective_size(c_raw, MAX_COLS_DEF);
      rows_eff = effective_size(r_raw, MAX_ROWS_DEF);
      n_sizes++;
   endtask

   // corners, thresholds, plane three and outside positions
   task automatic drive_corner_cases();
      send_item(ACT_LOAD,   16'h0100, 16'h0100, 2'd0, 16'hFFFF);
      send_item(ACT_LOAD,   16'h0200, 16'h0100, 2'd0, 16'h0000);
      send_item(ACT_LOAD,   16'h0100, 16'h0200, 2'd0, 16'h8000);
      send_item(ACT_LOAD,   16'h0200, 16'h0200, 2'd0, 16'h1234);
      send_item(ACT_LOAD,   16'h0000, 16'h0000, 2'd0, 16'hABCD);
      send_item(ACT_LOAD,   16'hFF00, 16'hFF00, 2'd2, 16'hFFFF);
      send_item(ACT_LOAD,   16'h0100, 16'h0100, 2'd3, 16'h5555);
      send_item(ACT_SAMPLE, 16'h0100, 16'h0100, 2'd0, 16'h0000);
      send_item(ACT_SAMPLE, 16'h0102, 16'h0102, 2'd0, 16'h0000);
      send_item(ACT_SAMPLE, 16'h0103, 16'h0100, 2'd0, 16'h0000);
      send_item(ACT_SAMPLE, 16'h0180, 16'h0180, 2'd0, 16'h0000);
      send_item(ACT_SAMPLE, 16'h01FF, 16'h01FF, 2'd0, 16'hFFFF);
      send_item(ACT_SAMPLE, 16'h0080, 16'h0080, 2'd0, 16'h0000);
      // ceil neighbor beyond the last column and row
      send_item(ACT_SAMPLE, 16'hFF80, 16'hFF80, 2'd2, 16'h0000);
      send_item(ACT_SAMPLE, 16'h0180, 16'h0180, 2'd3, 16'h0000);
      settle_block();
      write_size(9'd5, 9'd4);
      send_item(ACT_LOAD,   16'h0500, 16'h0000, 2'd0, 16'h7777);
      send_item(ACT_LOAD,   16'h0100, 16'h0100, 2'd1, 16'h0001);
      send_item(ACT_SAMPLE, 16'h0500, 16'h0000, 2'd0, 16'h0000);
      send_item(ACT_SAMPLE, 16'h0000, 16'h0400, 2'd1, 16'h0000);
      send_item(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF);
      send_item(ACT_SAMPLE, 16'h0180, 16'h0180, 2'd0, 16'h0000);
      send_item(ACT_SAMPLE, 16'h0100, 16'h0100, 2'd1, 16'h0000);
   endtask

   // one image size: fill a region, then a random mix of loads and samples
   task automatic run_phase(input logic [CSR_DATA_W-1:0] c_raw,
                            input logic [CSR_DATA_W-1:0] r_raw, input int n_random);
      patch_t          patches[$];
      patch_t          p;
      int unsigned     pw, ph, x, y, ch, pick, tries;
      logic [POS_W-1:0] px, py;
      bit              found;
      settle_block();
      write_size(c_raw, r_raw);
      if (cols_eff * rows_eff <= 100) begin
         patches.push_back('{0, 0, cols_eff, rows_eff});
      end else begin
         pw = (cols_eff < 5) ? cols_eff : 5;
         ph = (rows_eff < 5) ? rows_eff : 5;
         patches.push_back('{0, 0, pw, ph});
         patches.push_back('{cols_eff - pw, rows_eff - ph, pw, ph});
      end
      // fill every plane of every patch
      foreach (patches[i]) begin
         for (ch = 0; ch < PLANES; ch++) begin
            for (y = patches[i].y0; y < patches[i].y0 + patches[i].h; y++) begin
               for (x = patches[i].x0; x < patches[i].x0 + patches[i].w; x++) begin
                  send_item(ACT_LOAD, 16'((x << 8) | $urandom_range(0, 255)),
                            16'((y << 8) | $urandom_range(0, 255)), 2'(ch),
                            16'($urandom));
               end
            end
         end
      end
      for (int k = 0; k < n_random; k++) begin
         if (k == n_random / 2) settle_block();
         if ($urandom_range(0, 39) == 0) burst = !burst;
         pick = $urandom_range(0, 99);
         p    = patches[$urandom_range(0, patches.size() - 1)];
         x    = p.x0 + $urandom_range(0, p.w - 1);
         y    = p.y0 + $urandom_range(0, p.h - 1);
         if (pick < 15) begin
            // overwrite a pixel of the filled region
            send_item(ACT_LOAD, 16'((x << 8) | $urandom_range(0, 255)),
                      16'((y << 8) | $urandom_range(0, 255)),
                      2'($urandom_range(0, PLANES - 1)), 16'($urandom));
         end else if (pick < 23) begin
            // load with arbitrary fields, often ignored
            send_item(ACT_LOAD, 16'($urandom), 16'($urandom), 2'($urandom_range(0, 3)),
                      16'($urandom));
         end else if (pick < 33) begin
            // arbitrary position, mostly outside on small images
            px = 16'($urandom);
            py = 16'($urandom);
            ch = $urandom_range(0, 3);
            if (!reads_written(ch, px, py)) begin
               px = 16'(x << 8);
               py = 16'(y << 8);
            end
            send_item(ACT_SAMPLE, px, py, 2'(ch), 16'($urandom));
         end else if (pick < 38) begin
            send_item(ACT_SAMPLE, 16'($urandom), 16'($urandom), 2'd3, 16'($urandom));
         end else begin
            // interpolation inside the filled region
            found = 1'b0;
            ch    = 0;
            for (tries = 0; tries < 8 && !found; tries++) begin
               p  = patches[$urandom_range(0, patches.size() - 1)];
               x  = p.x0 + $urandom_range(0, p.w - 1);
               y  = p.y0 + $urandom_range(0, p.h - 1);
               px = 16'((x << 8) | frac_draw());
               py = 16'((y << 8) | frac_draw());
               ch = $urandom_range(0, PLANES - 1);
               found = reads_written(ch, px, py);
            end
            if (!found) begin
               px = 16'(x << 8);
               py = 16'(y << 8);
            end
            send_item(ACT_SAMPLE, px, py, 2'(ch), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_corner_cases();
      run_phase(9'd0,   9'd2,   60);
      run_phase(9'd3,   9'd5,   80);
      run_phase(9'd256, 9'd1,   80);
      run_phase(9'd2,   9'd256, 80);
      run_phase(9'd7,   9'd9,   90);
      run_phase(9'd16,  9'd12,  90);
      run_phase(9'd511, 9'd300, 90);
      run_phase(9'd256, 9'd256, 90);
      settle_block();
      $display("covered %0d loads and %0d samples over %0d image size settings",
               n_loads, n_samples, n_sizes);
      $display("sizes from 2x2 to 256x256, out-of-range register values included");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
